FILE: rtl/bfsb_pkg.sv
package bfsb_pkg;

    localparam int CURSOR_W = 12;
    localparam int COUNT_W  = 7;
    localparam int WORD_W   = 64;
    localparam logic [COUNT_W-1:0] FIELD_MAX = 7'd64;

    typedef enum logic [1:0] {
        OP_READ_U = 2'd0,
        OP_READ_S = 2'd1,
        OP_WRITE  = 2'd2,
        OP_SEEK   = 2'd3
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture the request fields
        logic clear_step;  // zero one memory word, advance the sweep address
        logic rd_hi;       // address the second word of the field
        logic cap0;        // capture the first word
        logic cap1;        // capture the second word
        logic wr0;         // write back the first word
        logic wr1;         // write back the second word
        logic finish;      // load the result register, update the cursor
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;    // sweep address is on the last word
        logic access;      // request touches the memory
        logic two_words;   // field straddles a word boundary
        logic is_write;
        logic out_busy;    // result register holds a result not yet taken
    } dp_status_t;

endpackage

FILE: rtl/bfsb_dpath.sv
module bfsb_dpath #(
    parameter int STORE_BYTES = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bfsb_pkg::dp_cmd_t                   cmd,
    output bfsb_pkg::dp_status_t                status,
    input  logic                                cfg_wr_en,
    input  logic [bfsb_pkg::CURSOR_W-1:0]       cfg_wr_data,
    input  logic [1:0]                          s_op,
    input  logic [bfsb_pkg::COUNT_W-1:0]        s_count,
    input  logic [bfsb_pkg::WORD_W-1:0]         s_wr_value,
    input  logic [bfsb_pkg::CURSOR_W-1:0]       s_new_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bfsb_pkg::WORD_W-1:0]         m_rd_value,
    output logic [bfsb_pkg::COUNT_W-1:0]        m_bits_done,
    output logic                                m_status,
    output logic [bfsb_pkg::CURSOR_W-1:0]       m_cursor
);
    import bfsb_pkg::*;

    localparam int WORDS = (STORE_BYTES + 7) / 8;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [15:0] CAP_BITS = 16'(STORE_BYTES * 8);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    op_t                 op_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [WORD_W-1:0]   wr_reg;
    logic [CURSOR_W-1:0] newpos_reg;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [CURSOR_W-1:0] length_reg;
    logic [WORD_W-1:0]   win0_reg, win1_reg, rdata_reg;
    logic [AW-1:0]       clr_addr_reg;

    logic                m_valid_reg;
    logic [WORD_W-1:0]   rd_value_reg, rd_value_next;
    logic [COUNT_W-1:0]  bits_done_reg, bits_done_next;
    logic                status_reg, status_next;

    logic [WORD_W-1:0]   mem [WORDS];

    logic [CURSOR_W-1:0] len, avail;
    logic [COUNT_W-1:0]  n_rd, fld;
    logic [5:0]          off;
    logic                ovr, is_read, is_write, access, two_words;
    logic [7:0]          sh;
    logic [WORD_W-1:0]   mask, rd_raw, rd_full;
    logic [2*WORD_W-1:0] rd_shift, pat;
    logic [AW-1:0]       addr0, addr1, mem_raddr, mem_waddr;
    logic                mem_we;
    logic [WORD_W-1:0]   mem_wdata;

    // Field geometry
    always_comb begin
        if ({4'b0, length_reg} < CAP_BITS) begin
            len = length_reg;
        end else begin
            len = CAP_BITS[CURSOR_W-1:0];
        end
        avail    = (cursor_reg < len) ? len - cursor_reg : '0;
        n_rd     = ({5'b0, count_reg} < avail) ? count_reg : avail[COUNT_W-1:0];
        ovr      = ({1'b0, cursor_reg} + 13'(count_reg)) > {1'b0, len};
        is_read  = (op_reg == OP_READ_U) || (op_reg == OP_READ_S);
        is_write = (op_reg == OP_WRITE);
        fld      = is_write ? count_reg : n_rd;
        off      = cursor_reg[5:0];
        access   = (is_read && n_rd != '0) || (is_write && count_reg != '0 && !ovr);
        two_words = ({1'b0, off} + fld) > FIELD_MAX;
        sh       = 8'd128 - {2'b0, off} - {1'b0, fld};
        mask     = ~({WORD_W{1'b1}} << fld);
        rd_shift = {win0_reg, win1_reg} >> sh;
        rd_raw   = rd_shift[WORD_W-1:0] & mask;
        rd_full  = rd_raw;
        if (op_reg == OP_READ_S && fld != '0 && fld < FIELD_MAX
            && rd_raw[6'(fld - 7'd1)]) begin
            rd_full = rd_raw | ~mask;
        end
        pat      = {{WORD_W{1'b0}}, wr_reg & mask} << sh;
    end

    // Result and cursor
    always_comb begin
        rd_value_next  = '0;
        bits_done_next = '0;
        status_next    = 1'b0;
        cursor_next    = cursor_reg;
        case (op_reg)
            OP_READ_U, OP_READ_S: begin
                rd_value_next  = rd_full;
                bits_done_next = n_rd;
                cursor_next    = cursor_reg + 12'(n_rd);
            end
            OP_WRITE: begin
                if (count_reg != '0) begin
                    if (ovr) begin
                        status_next = 1'b1;
                    end else begin
                        bits_done_next = count_reg;
                        cursor_next    = cursor_reg + 12'(count_reg);
                    end
                end
            end
            OP_SEEK: begin
                cursor_next = (newpos_reg < len) ? newpos_reg : len;
            end
            default: begin
                cursor_next = cursor_reg;
            end
        endcase
    end

    // Memory port selection
    assign addr0     = AW'(cursor_reg[11:6]);
    assign addr1     = AW'({1'b0, cursor_reg[11:6]} + 7'd1);
    assign mem_raddr = cmd.rd_hi ? addr1 : addr0;
    assign mem_we    = cmd.clear_step | cmd.wr0 | cmd.wr1;

    always_comb begin
        if (cmd.clear_step) begin
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (cmd.wr1) begin
            mem_waddr = addr1;
            mem_wdata = win1_reg | pat[WORD_W-1:0];
        end else begin
            mem_waddr = addr0;
            mem_wdata = win0_reg | pat[2*WORD_W-1:WORD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= op_t'(s_op);
            count_reg  <= (s_count > FIELD_MAX) ? FIELD_MAX : s_count;
            wr_reg     <= s_wr_value;
            newpos_reg <= s_new_position;
        end
        if (cmd.cap0) begin
            win0_reg <= rdata_reg;
        end
        if (cmd.cap1) begin
            win1_reg <= rdata_reg;
        end
        if (cmd.finish) begin
            rd_value_reg  <= rd_value_next;
            bits_done_reg <= bits_done_next;
            status_reg    <= status_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg   <= '0;
            length_reg   <= 12'd2048;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                length_reg <= cfg_wr_data;
            end
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.finish) begin
                cursor_reg  <= cursor_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clr_last  = (clr_addr_reg == LAST_WORD);
    assign status.access    = access;
    assign status.two_words = two_words;
    assign status.is_write  = is_write;
    assign status.out_busy  = m_valid_reg && !m_ready;

    assign m_valid     = m_valid_reg;
    assign m_rd_value  = rd_value_reg;
    assign m_bits_done = bits_done_reg;
    assign m_status    = status_reg;
    assign m_cursor    = cursor_reg;

endmodule

FILE: rtl/bfsb_ctrl.sv
module bfsb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output bfsb_pkg::dp_cmd_t     cmd,
    input  bfsb_pkg::dp_status_t  status
);
    import bfsb_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD0,
        ST_RD1,
        ST_WR0,
        ST_WR1,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_comb begin
        cmd            = '0;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.load       = (state_reg == ST_IDLE) && s_valid && ready_reg;
        cmd.rd_hi      = (state_reg == ST_RD0);
        cmd.cap0       = (state_reg == ST_RD0);
        cmd.cap1       = (state_reg == ST_RD1);
        cmd.wr0        = (state_reg == ST_WR0);
        cmd.wr1        = (state_reg == ST_WR1);
        cmd.finish     = (state_reg == ST_DONE) && !status.out_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    if (status.clr_last) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid && ready_reg) begin
                        state_reg <= ST_DECODE;
                        ready_reg <= 1'b0;
                    end
                end
                ST_DECODE: begin
                    state_reg <= status.access ? ST_RD0 : ST_DONE;
                end
                ST_RD0: begin
                    if (status.two_words) begin
                        state_reg <= ST_RD1;
                    end else begin
                        state_reg <= status.is_write ? ST_WR0 : ST_DONE;
                    end
                end
                ST_RD1: begin
                    state_reg <= status.is_write ? ST_WR0 : ST_DONE;
                end
                ST_WR0: begin
                    state_reg <= status.two_words ? ST_WR1 : ST_DONE;
                end
                ST_WR1: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!status.out_busy) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_ready = ready_reg;

endmodule

FILE: rtl/bit_field_stream_buffer.sv
// Bit field stream buffer: a byte store with a bit cursor, read and written as
// MSB-first fields of 0 to 64 bits (bit 0 is the MSB of byte 0). Each request
// on s_ is one of read unsigned, read signed, write (OR into the store) or
// seek, and yields exactly one result on m_ with the field read, the bits
// handled, an overrun flag for a rejected write, and the cursor afterwards.
// The store is kept as 64-bit words in one memory with a read and a write
// port; a field spans at most two words, fetched one per cycle and, for
// writes, written back one per cycle. A request is decoded, then reads its
// word or words, writes them back if it is a write, and completes by loading
// the result register; one that touches no memory (seek, zero width, rejected
// write) goes from decode straight to completion. The next request is taken
// in the cycle after the result is loaded, even while that result still waits.
// After reset the block sweeps the memory to zero, one word per cycle, over
// all (STORE_BYTES+7)/8 words, with s_ready low; the length register accepts
// writes during that sweep. Write the length only while the block is idle.
module bit_field_stream_buffer #(
    parameter int STORE_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [6:0]  s_count,
    input  logic [63:0] s_wr_value,
    input  logic [11:0] s_new_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_rd_value,
    output logic [6:0]  m_bits_done,
    output logic        m_status,
    output logic [11:0] m_cursor
);
    import bfsb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence the memory accesses for each request
    bfsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Hold the store, cursor, length and result register
    bfsb_dpath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_op           (s_op),
        .s_count        (s_count),
        .s_wr_value     (s_wr_value),
        .s_new_position (s_new_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rd_value     (m_rd_value),
        .m_bits_done    (m_bits_done),
        .m_status       (m_status),
        .m_cursor       (m_cursor)
    );

`ifndef NO_ASSERTIONS
    // A rejected write handles no bits and reads nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_bits_done == 7'd0 && m_rd_value == 64'd0)
        else $error("overrun result carries data");

    // Never more bits than the widest field
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_bits_done <= 7'd64)
        else $error("bits_done above field limit");

    // One request in flight: ready drops after acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // The completion step always presents the loaded result
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("result not presented after completion");
`endif

endmodule
